// ----- rtl/sbn_pkg.sv -----
package sbn_pkg;

  // Default sizes of the register file and program counter
  localparam int unsigned NumRegsDef   = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned PcWidthDef   = 16;

  // Fixed stream widths
  localparam int unsigned InTdataW  = 128;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = 56;

  // Fixed field widths
  localparam int unsigned ValW     = 32;
  localparam int unsigned DestW    = 4;
  localparam int unsigned JmodeW   = 2;
  localparam int unsigned JvalW    = 17;
  localparam int unsigned OutPcW   = 16;

  // Operation codes
  typedef enum logic [1:0] {
    OP_SBN    = 2'd0,
    OP_INPUT  = 2'd1,
    OP_OUTPUT = 2'd2,
    OP_LINK   = 2'd3
  } op_e;

  // Branch target kinds; the unused code falls back to absolute
  localparam logic [JmodeW-1:0] JMP_ABS = 2'd0;
  localparam logic [JmodeW-1:0] JMP_REL = 2'd1;
  localparam logic [JmodeW-1:0] JMP_REG = 2'd2;

endpackage

// ----- rtl/sbn_ram.sv -----
module sbn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads; a read during a write returns the old data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ----- rtl/sbn_oisc_execute_unit.sv -----
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid_i/tready_o      tdata: decoded instruction, tuser: op
// m_axis    out  m_axis_tvalid_o/tready_i      tdata: next pc, branch flag, output value
//
// One instruction per cycle while the output is not stalled; each passes the execute stage, then the output register.
// Acceptance issues register file reads; the execute stage executes, writes back and updates pc.
// A write in the same cycle as a read of that register is forwarded.
// Reset clears pc and the valid bits of the register file; unwritten registers read zero.
// A stalled result holds in the output register; the input stalls once execute is also full.
module sbn_oisc_execute_unit #(
  parameter int unsigned NUM_REGS   = sbn_pkg::NumRegsDef,
  parameter int unsigned DATA_WIDTH = sbn_pkg::DataWidthDef,
  parameter int unsigned PC_WIDTH   = sbn_pkg::PcWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // a_is_reg, a_value, b_is_reg, b_value, dest_reg, jump_mode, jump_value, in_value, pad
  input  logic [sbn_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // op
  input  logic [sbn_pkg::InTuserW-1:0]   s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // next_pc, branch_taken, out_valid, out_value, pad
  output logic [sbn_pkg::OutTdataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(NUM_REGS);
  localparam int unsigned SumW = IdxW + 5;

  // Reduce a value mod NUM_REGS: weighted sum of bit residues, then restoring subtracts
  function automatic logic [IdxW-1:0] reg_idx(input logic [31:0] x);
    logic [SumW-1:0] acc;
    logic [SumW-1:0] w;
    acc = '0;
    w   = SumW'(1);
    for (int i = 0; i < 32; i++) begin
      if (x[i]) acc = acc + w;
      w = w << 1;
      if (w >= SumW'(NUM_REGS)) w = w - SumW'(NUM_REGS);
    end
    for (int k = 4; k >= 0; k--) begin
      if (acc >= (SumW'(NUM_REGS) << k)) acc = acc - (SumW'(NUM_REGS) << k);
    end
    return acc[IdxW-1:0];
  endfunction

  // Sign-extend a 32-bit literal and wrap it to the data width
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [31:0] x);
    logic [63:0] t;
    t = {{32{x[31]}}, x};
    return t[DATA_WIDTH-1:0];
  endfunction

  // Input fields
  sbn_pkg::op_e                 in_op;
  logic                         in_a_is_reg;
  logic [sbn_pkg::ValW-1:0]     in_a_value;
  logic                         in_b_is_reg;
  logic [sbn_pkg::ValW-1:0]     in_b_value;
  logic [sbn_pkg::DestW-1:0]    in_dest;
  logic [sbn_pkg::JmodeW-1:0]   in_jmode;
  logic [sbn_pkg::JvalW-1:0]    in_jval;
  logic [sbn_pkg::ValW-1:0]     in_value;

  assign in_op       = sbn_pkg::op_e'(s_axis_tuser_i);
  assign in_a_is_reg = s_axis_tdata_i[0];
  assign in_a_value  = s_axis_tdata_i[32:1];
  assign in_b_is_reg = s_axis_tdata_i[33];
  assign in_b_value  = s_axis_tdata_i[65:34];
  assign in_dest     = s_axis_tdata_i[69:66];
  assign in_jmode    = s_axis_tdata_i[71:70];
  assign in_jval     = s_axis_tdata_i[88:72];
  assign in_value    = s_axis_tdata_i[120:89];

  logic [IdxW-1:0] a_idx, b_idx, j_idx, d_idx;
  assign a_idx = reg_idx(in_a_value);
  assign b_idx = reg_idx(in_b_value);
  assign j_idx = reg_idx(32'(in_jval));
  assign d_idx = reg_idx(32'(in_dest));

  // Handshake
  logic s_accept, s1_adv;
  logic s1_vld_q, out_vld_q;
  assign s1_adv          = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || s1_adv;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Write-back port
  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;

  // Register file, kept as two copies for four read ports
  logic [DATA_WIDTH-1:0] rd_a, rd_b, rd_j, rd_d;

  sbn_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_ram_ab (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (s_accept),
    .raddr0_i (a_idx),
    .raddr1_i (b_idx),
    .rdata0_o (rd_a),
    .rdata1_o (rd_b)
  );

  sbn_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_ram_jd (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (s_accept),
    .raddr0_i (j_idx),
    .raddr1_i (d_idx),
    .rdata0_o (rd_j),
    .rdata1_o (rd_d)
  );

  // Control state: stage valid, pc, register valid bits, forward record
  logic [NUM_REGS-1:0]   vld_q;
  logic [PC_WIDTH-1:0]   pc_q, pc_d;
  logic                  fwd_we_q;
  logic [IdxW-1:0]       fwd_addr_q;
  logic [DATA_WIDTH-1:0] fwd_data_q;

  // Execute-stage payload
  sbn_pkg::op_e               s1_op_q;
  logic                       s1_a_is_reg_q, s1_b_is_reg_q;
  logic [DATA_WIDTH-1:0]      s1_a_lit_q, s1_b_lit_q, s1_in_q;
  logic [IdxW-1:0]            s1_a_idx_q, s1_b_idx_q, s1_j_idx_q, s1_d_idx_q;
  logic                       s1_a_vld_q, s1_b_vld_q, s1_j_vld_q, s1_d_vld_q;
  logic [sbn_pkg::JmodeW-1:0] s1_jmode_q;
  logic [sbn_pkg::JvalW-1:0]  s1_jval_q;

  // Output register payload
  logic [sbn_pkg::OutPcW-1:0] out_pc_q, out_pc_d;
  logic                       out_taken_q, out_taken_d;
  logic                       out_ov_q, out_ov_d;
  logic [sbn_pkg::ValW-1:0]   out_value_q, out_value_d;

  // Capture the instruction and the valid bits of the registers it reads
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_op_q       <= in_op;
      s1_a_is_reg_q <= in_a_is_reg;
      s1_b_is_reg_q <= in_b_is_reg;
      s1_a_lit_q    <= to_data(in_a_value);
      s1_b_lit_q    <= to_data(in_b_value);
      s1_in_q       <= to_data(in_value);
      s1_a_idx_q    <= a_idx;
      s1_b_idx_q    <= b_idx;
      s1_j_idx_q    <= j_idx;
      s1_d_idx_q    <= d_idx;
      s1_a_vld_q    <= vld_q[a_idx];
      s1_b_vld_q    <= vld_q[b_idx];
      s1_j_vld_q    <= vld_q[j_idx];
      s1_d_vld_q    <= vld_q[d_idx];
      s1_jmode_q    <= in_jmode;
      s1_jval_q     <= in_jval;
      fwd_addr_q    <= ram_waddr;
      fwd_data_q    <= ram_wdata;
    end
  end

  // Resolve register reads: forward the write made as the read was issued
  function automatic logic [DATA_WIDTH-1:0] resolve(input logic [IdxW-1:0] idx,
                                                    input logic vld,
                                                    input logic [DATA_WIDTH-1:0] ram,
                                                    input logic fwd_we,
                                                    input logic [IdxW-1:0] fwd_addr,
                                                    input logic [DATA_WIDTH-1:0] fwd_val);
    logic [DATA_WIDTH-1:0] r;
    r = vld ? ram : '0;
    if (fwd_we && fwd_addr == idx) r = fwd_val;
    return r;
  endfunction

  logic [DATA_WIDTH-1:0] reg_a, reg_b, reg_j, reg_d;
  logic [DATA_WIDTH-1:0] opa, opb, diff;
  assign reg_a = resolve(s1_a_idx_q, s1_a_vld_q, rd_a, fwd_we_q, fwd_addr_q, fwd_data_q);
  assign reg_b = resolve(s1_b_idx_q, s1_b_vld_q, rd_b, fwd_we_q, fwd_addr_q, fwd_data_q);
  assign reg_j = resolve(s1_j_idx_q, s1_j_vld_q, rd_j, fwd_we_q, fwd_addr_q, fwd_data_q);
  assign reg_d = resolve(s1_d_idx_q, s1_d_vld_q, rd_d, fwd_we_q, fwd_addr_q, fwd_data_q);
  assign opa   = s1_a_is_reg_q ? reg_a : s1_a_lit_q;
  assign opb   = s1_b_is_reg_q ? reg_b : s1_b_lit_q;
  assign diff  = opa - opb;

  // Branch target and next pc
  logic [63:0]           jv_ext, regj_ext, pc_ext, regd_ext;
  logic [PC_WIDTH-1:0]   pc_inc, target;
  logic                  taken;
  assign jv_ext   = {{(64 - sbn_pkg::JvalW){s1_jval_q[sbn_pkg::JvalW-1]}}, s1_jval_q};
  assign regj_ext = 64'(reg_j);
  assign regd_ext = 64'(reg_d);
  assign pc_inc   = pc_q + PC_WIDTH'(1);
  assign pc_ext   = 64'(pc_d);

  always_comb begin
    case (s1_jmode_q)
      sbn_pkg::JMP_REL: target = pc_q + jv_ext[PC_WIDTH-1:0];
      sbn_pkg::JMP_REG: target = regj_ext[PC_WIDTH-1:0];
      default:          target = jv_ext[PC_WIDTH-1:0];
    endcase
  end

  assign taken = (s1_op_q == sbn_pkg::OP_SBN) && diff[DATA_WIDTH-1];
  assign pc_d  = taken ? target : pc_inc;

  // Write back per operation
  logic [63:0] link_ext;
  assign link_ext = 64'(pc_inc);

  always_comb begin
    ram_we    = s1_adv;
    ram_waddr = s1_d_idx_q;
    case (s1_op_q)
      sbn_pkg::OP_SBN:    ram_wdata = diff;
      sbn_pkg::OP_INPUT:  ram_wdata = s1_in_q;
      sbn_pkg::OP_LINK:   ram_wdata = link_ext[DATA_WIDTH-1:0];
      default: begin
        ram_we    = 1'b0;
        ram_wdata = s1_in_q;
      end
    endcase
  end

  // Result fields
  assign out_pc_d    = pc_ext[sbn_pkg::OutPcW-1:0];
  assign out_taken_d = taken;
  assign out_ov_d    = (s1_op_q == sbn_pkg::OP_OUTPUT);
  assign out_value_d = out_ov_d ? regd_ext[sbn_pkg::ValW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pc_q    <= out_pc_d;
      out_taken_q <= out_taken_d;
      out_ov_q    <= out_ov_d;
      out_value_q <= out_value_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= '0;
      vld_q     <= '0;
      fwd_we_q  <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_vld_q <= 1'b1;
        fwd_we_q <= ram_we;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
        pc_q      <= pc_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_value_q, out_ov_q, out_taken_q, out_pc_q};

  // Checks
  a_pc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(pc_q))
    else $error("pc changed without a retiring instruction");

  a_we_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> s1_vld_q)
    else $error("register write with empty execute stage");

  a_accept_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s1_vld_q) |-> s1_adv)
    else $error("accepted over a stalled execute stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> s1_vld_q)
    else $error("accepted item did not reach execute");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_taken_q) |-> !out_ov_q)
    else $error("branch and output flagged together");

endmodule

// ----- dv/sbn_exec_checker.sv -----
module sbn_exec_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // a_is_reg, a_value, b_is_reg, b_value, dest_reg, jump_mode, jump_value, in_value, pad
  input  logic [sbn_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // op
  input  logic [sbn_pkg::InTuserW-1:0]  s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // next_pc, branch_taken, out_valid, out_value, pad
  input  logic [sbn_pkg::OutTdataW-1:0] m_axis_tdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned IdxW = $clog2(sbn_pkg::NumRegsDef);

  typedef struct packed {
    logic [sbn_pkg::ValW-1:0]   in_value;
    logic [sbn_pkg::JvalW-1:0]  jump_value;
    logic [sbn_pkg::JmodeW-1:0] jump_mode;
    logic [sbn_pkg::DestW-1:0]  dest_reg;
    logic [sbn_pkg::ValW-1:0]   b_value;
    logic                       b_is_reg;
    logic [sbn_pkg::ValW-1:0]   a_value;
    logic                       a_is_reg;
  } instr_t;

  typedef struct packed {
    logic [sbn_pkg::ValW-1:0]   out_value;
    logic                       out_valid;
    logic                       branch_taken;
    logic [sbn_pkg::OutPcW-1:0] next_pc;
  } retire_t;

  logic [sbn_pkg::DataWidthDef-1:0] shadow_regs [sbn_pkg::NumRegsDef];
  logic [sbn_pkg::PcWidthDef-1:0]   shadow_pc;
  retire_t                          retire_q [$];

  // Execute one instruction on the shadow machine and return what it retires
  function automatic retire_t exec_instr(input sbn_pkg::op_e op, input instr_t ins);
    retire_t                          res;
    logic [sbn_pkg::DataWidthDef-1:0] src_a;
    logic [sbn_pkg::DataWidthDef-1:0] src_b;
    logic [sbn_pkg::DataWidthDef-1:0] diff;
    logic [sbn_pkg::PcWidthDef-1:0]   target;
    logic [sbn_pkg::PcWidthDef-1:0]   pc_inc;
    logic [IdxW-1:0]                  dst;
    res          = '0;
    pc_inc       = shadow_pc + 1'b1;
    dst          = ins.dest_reg[IdxW-1:0];
    res.next_pc  = pc_inc;
    case (op)
      sbn_pkg::OP_SBN: begin
        // read every source before the write-back
        src_a = ins.a_is_reg ? shadow_regs[ins.a_value[IdxW-1:0]] : ins.a_value;
        src_b = ins.b_is_reg ? shadow_regs[ins.b_value[IdxW-1:0]] : ins.b_value;
        case (ins.jump_mode)
          sbn_pkg::JMP_REL:
            target = shadow_pc + ins.jump_value[sbn_pkg::PcWidthDef-1:0];
          sbn_pkg::JMP_REG:
            target = shadow_regs[ins.jump_value[IdxW-1:0]][sbn_pkg::PcWidthDef-1:0];
          default:
            target = ins.jump_value[sbn_pkg::PcWidthDef-1:0];
        endcase
        diff = src_a - src_b;
        shadow_regs[dst] = diff;
        if (diff[sbn_pkg::DataWidthDef-1]) begin
          res.branch_taken = 1'b1;
          res.next_pc      = target;
        end
      end
      sbn_pkg::OP_INPUT:  shadow_regs[dst] = ins.in_value;
      sbn_pkg::OP_OUTPUT: begin
        res.out_valid = 1'b1;
        res.out_value = shadow_regs[dst];
      end
      default: shadow_regs[dst] =
        {{(sbn_pkg::DataWidthDef-sbn_pkg::PcWidthDef){1'b0}}, pc_inc};
    endcase
    shadow_pc = res.next_pc;
    return res;
  endfunction

  // Predict on every accepted instruction, compare every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    retire_t want;
    retire_t got;
    retire_t fresh;
    if (!rst_ni) begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      shadow_pc = '0;
      retire_q.delete();
      fail_count_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        fresh = exec_instr(sbn_pkg::op_e'(s_axis_tuser_i),
                           instr_t'(s_axis_tdata_i[$bits(instr_t)-1:0]));
        retire_q.insert(retire_q.size(), fresh);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = retire_t'(m_axis_tdata_i[$bits(retire_t)-1:0]);
        if (retire_q.size() == 0) begin
          $error("result with no instruction pending: tdata %h", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = retire_q.pop_front();
          if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %h, got %h", want.next_pc, got.next_pc);
            fail_count_o++;
          end
          if (got.branch_taken !== want.branch_taken) begin
            $error("branch_taken: expected %b, got %b", want.branch_taken, got.branch_taken);
            fail_count_o++;
          end
          if (got.out_valid !== want.out_valid) begin
            $error("out_valid: expected %b, got %b", want.out_valid, got.out_valid);
            fail_count_o++;
          end
          if (got.out_value !== want.out_value) begin
            $error("out_value: expected %h, got %h", want.out_value, got.out_value);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = retire_q.size();
  end

endmodule

// ----- dv/tb_sbn_oisc_execute_unit.sv -----
module tb_sbn_oisc_execute_unit;

  // Jump kind with no code of its own; the block treats it as absolute
  localparam logic [sbn_pkg::JmodeW-1:0] JmpSpare = 2'd3;
  localparam int                         NumRandom = 1250;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [sbn_pkg::InTdataW-1:0]   s_axis_tdata = '0;
  logic [sbn_pkg::InTuserW-1:0]   s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [sbn_pkg::OutTdataW-1:0]  m_axis_tdata;
  int                             fail_count;
  int                             pending;

  // Idle controls set by the stimulus: tx_idle is read by the sender, rx_idle and hold_req by the receiver
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  sbn_oisc_execute_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  sbn_exec_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Offer one instruction, with an optional idle burst first, and hold until accepted
  task automatic send_instr(input sbn_pkg::op_e op, input logic a_reg,
                            input logic [sbn_pkg::ValW-1:0] a_val,
                            input logic b_reg, input logic [sbn_pkg::ValW-1:0] b_val,
                            input logic [sbn_pkg::DestW-1:0] dest,
                            input logic [sbn_pkg::JmodeW-1:0] jmode,
                            input logic [sbn_pkg::JvalW-1:0] jval,
                            input logic [sbn_pkg::ValW-1:0] in_val);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(sbn_pkg::InTdataW-121){1'b0}}, in_val, jval, jmode, dest,
                      b_val, b_reg, a_val, a_reg};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // One random instruction, half of them sbn, with registers loaded by input
  task automatic send_random();
    sbn_pkg::op_e               op;
    int                         pick;
    int                         jr;
    logic [sbn_pkg::JvalW-1:0]  jv;
    logic [sbn_pkg::JmodeW-1:0] jm;
    pick = $urandom_range(0, 99);
    if (pick < 50)      op = sbn_pkg::OP_SBN;
    else if (pick < 72) op = sbn_pkg::OP_INPUT;
    else if (pick < 90) op = sbn_pkg::OP_OUTPUT;
    else                op = sbn_pkg::OP_LINK;
    jr = $urandom_range(0, 98303) - 32768;
    jv = jr[sbn_pkg::JvalW-1:0];
    jm = ($urandom_range(0, 19) == 0) ? JmpSpare : 2'($urandom_range(0, 2));
    send_instr(op, 1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)), $urandom,
               4'($urandom_range(0, 15)), jm, jv, $urandom);
  endtask

  // Receiver: random stalls, one long hold-off on request, none in the last part
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int guard;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset contents, data extremes, every jump kind, wrap and ordering cases
    send_instr(sbn_pkg::OP_OUTPUT, 1'b0, '0, 1'b0, '0, 4'd5, sbn_pkg::JMP_ABS, '0, '0);
    send_instr(sbn_pkg::OP_INPUT, 1'b0, '0, 1'b0, '0, 4'd1, sbn_pkg::JMP_ABS, '0,
               32'h8000_0000);
    send_instr(sbn_pkg::OP_INPUT, 1'b0, '0, 1'b0, '0, 4'd2, sbn_pkg::JMP_ABS, '0,
               32'h7FFF_FFFF);
    send_instr(sbn_pkg::OP_INPUT, 1'b0, '0, 1'b0, '0, 4'd3, sbn_pkg::JMP_ABS, '0,
               32'hFFFF_FFFF);
    send_instr(sbn_pkg::OP_OUTPUT, 1'b1, '1, 1'b1, '1, 4'd1, sbn_pkg::JMP_ABS, '1, '1);
    // literal subtract that wraps to positive
    send_instr(sbn_pkg::OP_SBN, 1'b0, 32'h8000_0000, 1'b0, 32'd1, 4'd4, sbn_pkg::JMP_ABS,
               17'd5, '0);
    // register index taken from the low bits only
    send_instr(sbn_pkg::OP_SBN, 1'b1, 32'hFFFF_FFF1, 1'b1, 32'h0000_0012, 4'd1,
               sbn_pkg::JMP_ABS, 17'd9, '0);
    // taken branch to the top of the pc range
    send_instr(sbn_pkg::OP_SBN, 1'b0, 32'd0, 1'b0, 32'd1, 4'd8, sbn_pkg::JMP_ABS,
               17'h0_FFFF, '0);
    // link at the top of the range wraps to zero
    send_instr(sbn_pkg::OP_LINK, 1'b0, '0, 1'b0, '0, 4'd6, sbn_pkg::JMP_ABS, '0, '0);
    send_instr(sbn_pkg::OP_OUTPUT, 1'b0, '0, 1'b0, '0, 4'd6, sbn_pkg::JMP_ABS, '0, '0);
    // relative offset of -32768
    send_instr(sbn_pkg::OP_SBN, 1'b0, 32'd0, 1'b0, 32'h7FFF_FFFF, 4'd9, sbn_pkg::JMP_REL,
               17'h1_8000, '0);
    send_instr(sbn_pkg::OP_INPUT, 1'b0, '0, 1'b0, '0, 4'd7, sbn_pkg::JMP_ABS, '0,
               32'h1234_5678);
    // register target, upper index bits ignored
    send_instr(sbn_pkg::OP_SBN, 1'b1, 32'd0, 1'b0, 32'd1, 4'd10, sbn_pkg::JMP_REG,
               17'h1_FFF7, '0);
    // spare jump kind behaves as absolute, target wraps to the pc width
    send_instr(sbn_pkg::OP_SBN, 1'b0, 32'h8000_0000, 1'b0, 32'd0, 4'd11, JmpSpare,
               17'h1_0003, '0);
    // destination is also source and jump register: all read before the write
    send_instr(sbn_pkg::OP_SBN, 1'b1, 32'd3, 1'b0, 32'd1, 4'd3, sbn_pkg::JMP_REG,
               17'd3, '0);
    send_instr(sbn_pkg::OP_OUTPUT, 1'b0, '0, 1'b0, '0, 4'd3, sbn_pkg::JMP_ABS, '0, '0);
    send_instr(sbn_pkg::OP_LINK, 1'b0, '0, 1'b0, '0, 4'd15, sbn_pkg::JMP_ABS, '0, '0);
    send_instr(sbn_pkg::OP_OUTPUT, 1'b0, '0, 1'b0, '0, 4'd15, sbn_pkg::JMP_ABS, '0, '0);
    // register minus itself is zero: not taken
    send_instr(sbn_pkg::OP_SBN, 1'b1, 32'd2, 1'b1, 32'd2, 4'd12, sbn_pkg::JMP_ABS,
               17'd0, '0);
    // largest positive relative offset, followed by a dependent read
    send_instr(sbn_pkg::OP_SBN, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 4'd13,
               sbn_pkg::JMP_REL, 17'h0_FFFF, '0);
    send_instr(sbn_pkg::OP_SBN, 1'b1, 32'd13, 1'b1, 32'd12, 4'd14, sbn_pkg::JMP_REG,
               17'd13, '0);
    send_instr(sbn_pkg::OP_OUTPUT, 1'b0, '0, 1'b0, '0, 4'd14, sbn_pkg::JMP_ABS, '0, '0);
    send_instr(sbn_pkg::OP_INPUT, 1'b0, '0, 1'b0, '0, 4'd0, sbn_pkg::JMP_ABS, '0,
               32'h0000_0000);
    send_instr(sbn_pkg::OP_OUTPUT, 1'b0, '0, 1'b0, '0, 4'd0, sbn_pkg::JMP_ABS, '0, '0);

    // Random with idling on both sides
    repeat (NumRandom / 3) send_random();

    // Sender pause until the block has drained
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    // Long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    repeat (NumRandom / 3) send_random();

    // Last part with no idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (NumRandom - 2 * (NumRandom / 3)) send_random();
    s_axis_tvalid <= 1'b0;

    // Drain and let the pipeline settle
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_sbn_oisc_execute_unit: done, clean");
    end else begin
      $display("tb_sbn_oisc_execute_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_sbn_oisc_execute_unit: done, errors");
    $finish;
  end

endmodule
